[design/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and the hex digit function of the encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int ADDR_W = 16;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Release of a buffer bank once the back end has finished reading it.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    base = (nib > 4'd9) ? 8'h37 : 8'h30;
    return base + {4'h0, nib};
  endfunction

endpackage

[design/ihex_front.sv]
// ----------------------------------------------------------------------------
// ihex_front
// Accepts input items, writes data bytes into the current buffer bank and
// posts a record job when a bank fills or the end of input arrives.
// ----------------------------------------------------------------------------
module ihex_front
  import ihex_pkg::*;
#(
  parameter int RECORD_BYTES = 16,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_start_address,
  input  logic              q_full,
  output logic              job_push,
  output logic              job_bank,
  output logic [CNT_W-1:0]  job_cnt,
  output logic [ADDR_W-1:0] job_addr,
  output logic              job_eof,
  input  bank_rel_t         rel,
  output logic              wr_en,
  output logic [IDX_W:0]    wr_addr,
  output logic [7:0]        wr_data
);

  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  fill_r;
  logic              wb_r;
  logic [1:0]        busy_r;
  logic [1:0]        busy_nxt;
  logic              accept;
  logic              bank_full;
  logic              has_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r[wb_r] && !q_full;
  assign accept    = in_valid && in_ready;
  assign bank_full = (fill_r == CNT_W'(RECORD_BYTES - 1));
  assign has_data  = (in_kind == KIND_DATA) || (fill_r != '0);

  assign job_push = accept && ((in_kind == KIND_END) || bank_full);
  assign job_bank = wb_r;
  assign job_cnt  = (in_kind == KIND_END) ? fill_r : CNT_W'(RECORD_BYTES);
  assign job_addr = addr_r;
  assign job_eof  = (in_kind == KIND_END);

  assign wr_en   = accept && (in_kind == KIND_DATA);
  assign wr_addr = {wb_r, fill_r[IDX_W-1:0]};
  assign wr_data = in_data_byte;

  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (job_push && has_data) begin
      busy_nxt[wb_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      addr_r  <= '0;
      fill_r  <= '0;
      wb_r    <= 1'b0;
      busy_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (accept) begin
        if (in_kind == KIND_END) begin
          addr_r <= start_r;
          fill_r <= '0;
          if (has_data) begin
            wb_r <= !wb_r;
          end
        end else if (bank_full) begin
          addr_r <= addr_r + ADDR_W'(RECORD_BYTES);
          fill_r <= '0;
          wb_r   <= !wb_r;
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        start_r <= cfg_start_address;
        addr_r  <= cfg_start_address;
      end
    end
  end

endmodule

[design/ihex_jobq.sv]
// ----------------------------------------------------------------------------
// ihex_jobq
// Two-entry queue of record jobs between the front and the back end.
// ----------------------------------------------------------------------------
module ihex_jobq
  import ihex_pkg::*;
#(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/ihex_back.sv]
// ----------------------------------------------------------------------------
// ihex_back
// Holds the two-bank byte buffer and spells out each record job as ASCII text
// through a registered output stage, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module ihex_back
  import ihex_pkg::*;
#(
  parameter int RECORD_BYTES = 16,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_pop,
  input  logic              job_bank,
  input  logic [CNT_W-1:0]  job_cnt,
  input  logic [ADDR_W-1:0] job_addr,
  input  logic              job_eof,
  output bank_rel_t         rel,
  input  logic              wr_en,
  input  logic [IDX_W:0]    wr_addr,
  input  logic [7:0]        wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_character,
  output logic              out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COLON = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_CR    = 3'd5;
  localparam logic [2:0] S_LF    = 3'd6;

  localparam int MEM_DEPTH = 2 << IDX_W;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_data_r;

  logic [2:0]        state_r;
  logic              nib_r;
  logic [1:0]        hidx_r;
  logic [CNT_W-1:0]  didx_r;
  logic [7:0]        sum_r;
  logic [3:0]        lo_nib_r;
  logic              rec_eof_r;
  logic              bank_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic              eof_r;

  logic              out_valid_r;
  logic [7:0]        out_character_r;
  logic              out_last_r;

  logic              advance;
  logic              more_rec;
  logic [7:0]        rec_cnt;
  logic [7:0]        rec_hi;
  logic [7:0]        rec_lo;
  logic [7:0]        rec_type;
  logic [7:0]        cur_byte;
  logic [7:0]        char_nxt;

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  assign advance  = !out_valid_r || out_ready;
  assign job_pop  = (state_r == S_IDLE) && job_valid;
  // After a data record of an end-of-input job, the EOF record follows.
  assign more_rec = !rec_eof_r && eof_r;

  assign rel.valid = advance && (state_r == S_LF) && !more_rec && (cnt_r != '0);
  assign rel.bank  = bank_r;

  assign rec_cnt  = rec_eof_r ? 8'h00 : 8'(cnt_r);
  assign rec_hi   = rec_eof_r ? 8'h00 : addr_r[15:8];
  assign rec_lo   = rec_eof_r ? 8'h00 : addr_r[7:0];
  assign rec_type = rec_eof_r ? REC_TYPE_EOF : REC_TYPE_DATA;

  always_comb begin
    case (state_r)
      S_HDR: begin
        case (hidx_r)
          2'd0:    cur_byte = rec_cnt;
          2'd1:    cur_byte = rec_hi;
          2'd2:    cur_byte = rec_lo;
          default: cur_byte = rec_type;
        endcase
      end
      S_DATA:  cur_byte = rd_data_r;
      S_SUM:   cur_byte = 8'h00 - sum_r;
      default: cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_COLON:              char_nxt = CHAR_COLON;
      S_HDR, S_DATA, S_SUM: char_nxt = nib_r ? hex_char(lo_nib_r) : hex_char(cur_byte[7:4]);
      S_CR:                 char_nxt = CHAR_CR;
      S_LF:                 char_nxt = CHAR_LF;
      default:              char_nxt = 8'h00;
    endcase
  end

  // The read port follows the data index every cycle; the low nibble is kept
  // aside when the high nibble goes out, so the index can move ahead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[{bank_r, didx_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_character_r <= char_nxt;
      out_last_r      <= (state_r == S_LF) && !more_rec;
    end
    if (job_pop) begin
      bank_r    <= job_bank;
      cnt_r     <= job_cnt;
      addr_r    <= job_addr;
      eof_r     <= job_eof;
      rec_eof_r <= (job_cnt == '0);
    end
    if (advance) begin
      case (state_r)
        S_COLON: begin
          sum_r  <= 8'h00;
          hidx_r <= 2'd0;
          didx_r <= '0;
        end
        S_HDR, S_DATA, S_SUM: begin
          if (!nib_r) begin
            lo_nib_r <= cur_byte[3:0];
            sum_r    <= sum_r + cur_byte;
            if (state_r == S_DATA) begin
              didx_r <= didx_r + CNT_W'(1);
            end
          end else if (state_r == S_HDR) begin
            hidx_r <= hidx_r + 2'd1;
          end
        end
        S_LF: begin
          if (more_rec) begin
            rec_eof_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nib_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= (state_r != S_IDLE);
      end
      if (job_pop) begin
        state_r <= S_COLON;
        nib_r   <= 1'b0;
      end else if (advance) begin
        unique case (state_r)
          S_IDLE: begin
          end
          S_COLON: begin
            state_r <= S_HDR;
            nib_r   <= 1'b0;
          end
          S_HDR: begin
            nib_r <= !nib_r;
            if (nib_r && (hidx_r == 2'd3)) begin
              state_r <= (rec_cnt == 8'h00) ? S_SUM : S_DATA;
            end
          end
          S_DATA: begin
            nib_r <= !nib_r;
            if (nib_r && (didx_r == cnt_r)) begin
              state_r <= S_SUM;
            end
          end
          S_SUM: begin
            nib_r <= !nib_r;
            if (nib_r) begin
              state_r <= S_CR;
            end
          end
          S_CR: begin
            state_r <= S_LF;
          end
          S_LF: begin
            state_r <= more_rec ? S_COLON : S_IDLE;
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

[design/intel_hex_record_encoder_core.sv]
// After the item that completes a record is accepted, its colon passes through the job
// queue, the back-end state register and the output register if the back end is idle.
// Characters go out one per cycle while out_ready holds; a record of N bytes is 2*N+13
// characters and the EOF record 13.
// Data bytes are taken one per cycle while a free buffer bank and a queue slot exist.
// Reset clears the control state; the start address and record address become 0.
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_core
// Intel HEX text encoder: a front end that buffers bytes into two banks, a
// two-entry job queue, and a back end that emits the record characters.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_core
  import ihex_pkg::*;
#(
  parameter int RECORD_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_character,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] cfg_start_address
);

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CNT_W = $clog2(RECORD_BYTES + 1);
  localparam int JOB_W = 1 + CNT_W + ADDR_W + 1;

  logic              q_full;
  logic              q_empty;
  logic              job_push;
  logic              job_pop;
  logic              f_bank;
  logic [CNT_W-1:0]  f_cnt;
  logic [ADDR_W-1:0] f_addr;
  logic              f_eof;
  logic [JOB_W-1:0]  q_head;
  bank_rel_t         rel;
  logic              wr_en;
  logic [IDX_W:0]    wr_addr;
  logic [7:0]        wr_data;

  ihex_front #(
    .RECORD_BYTES(RECORD_BYTES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_address(cfg_start_address),
    .q_full           (q_full),
    .job_push         (job_push),
    .job_bank         (f_bank),
    .job_cnt          (f_cnt),
    .job_addr         (f_addr),
    .job_eof          (f_eof),
    .rel              (rel),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  ihex_jobq #(
    .WIDTH(JOB_W)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data({f_bank, f_cnt, f_addr, f_eof}),
    .pop      (job_pop),
    .head_data(q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ihex_back #(
    .RECORD_BYTES(RECORD_BYTES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!q_empty),
    .job_pop      (job_pop),
    .job_bank     (q_head[JOB_W-1]),
    .job_cnt      (q_head[JOB_W-2 -: CNT_W]),
    .job_addr     (q_head[ADDR_W:1]),
    .job_eof      (q_head[0]),
    .rel          (rel),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full)
    else $error("job queue overflow");

  a_end_posts_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_END)) |=> !q_empty)
    else $error("end of input did not post a job");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_character == CHAR_LF))
    else $error("last beat is not a line feed");
`endif

endmodule

[sim/tb_intel_hex_record_encoder_core.sv]
// ----------------------------------------------------------------------------
// tb_intel_hex_record_encoder_core
// Drives raw bytes and end-of-input items into the Intel HEX encoder and
// checks every text character it emits against a predicted record stream.
// Covers full and partial records, bare EOF records, address wrap and
// start-address changes, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int REC_BYTES        = 16;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 3000;

  // Predicts the record text for each accepted beat and checks emitted chars.
  class ihex_text_tracker;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } text_beat_t;

    text_beat_t   pending_text[$];
    logic [15:0]  start_addr;
    logic [15:0]  next_addr;
    logic [7:0]   record_buf[REC_BYTES];
    int unsigned  fill;
    int unsigned  errors;
    string        digits;

    function new();
      start_addr = '0;
      next_addr  = '0;
      fill       = 0;
      errors     = 0;
      digits     = "0123456789ABCDEF";
    endfunction

    function int pending();
      return pending_text.size();
    endfunction

    function void push_char(logic [7:0] c);
      text_beat_t b;
      b.ch   = c;
      b.last = 1'b0;
      pending_text.push_back(b);
    endfunction

    function void push_hex(logic [7:0] v);
      push_char(digits[v[7:4]]);
      push_char(digits[v[3:0]]);
    endfunction

    function void push_record(logic [7:0] count, logic [15:0] addr, logic [7:0] rtype);
      logic [7:0] sum;
      sum = count + addr[15:8] + addr[7:0] + rtype;
      push_char(CHAR_COLON);
      push_hex(count);
      push_hex(addr[15:8]);
      push_hex(addr[7:0]);
      push_hex(rtype);
      for (int i = 0; i < count; i++) begin
        push_hex(record_buf[i]);
        sum = sum + record_buf[i];
      end
      push_hex(8'(~sum + 8'd1));
      push_char(CHAR_CR);
      push_char(CHAR_LF);
    endfunction

    function void flush_buffer();
      if (fill != 0) begin
        push_record(8'(fill), next_addr, REC_TYPE_DATA);
        next_addr = next_addr + 16'(fill);
        fill = 0;
      end
    endfunction

    function void load_start(logic [15:0] addr);
      start_addr = addr;
      next_addr  = addr;
    endfunction

    function void take_item(logic kind, logic [7:0] data);
      int before_n;
      before_n = pending_text.size();
      if (kind == KIND_DATA) begin
        record_buf[fill] = data;
        fill++;
        if (fill == REC_BYTES) flush_buffer();
      end else begin
        flush_buffer();
        push_record(8'h00, 16'h0000, REC_TYPE_EOF);
        next_addr = start_addr;
      end
      if (pending_text.size() > before_n) pending_text[pending_text.size() - 1].last = 1'b1;
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_beat_t want;
      if (pending_text.size() == 0) begin
        $error("unexpected character beat: character %h last %b", ch, last);
        errors++;
        return;
      end
      want = pending_text.pop_front();
      if (ch !== want.ch) begin
        $error("character: expected %h, actual %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [7:0]        in_data_byte;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_character;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_start_address;

  ihex_text_tracker tracker = new();
  int               send_idle_pct;
  int               recv_idle_pct;
  logic             long_hold_req;
  int               quiet_cycles = 0;

  intel_hex_record_encoder_core #(
    .RECORD_BYTES(REC_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_character    (out_character),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_start_address(cfg_start_address)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Input is noted before output is checked, so a same-edge beat is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_item(in_kind, in_data_byte);
      if (out_valid && out_ready) tracker.check_char(out_character, out_last);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     = 1'b1;
    in_kind      = kind;
    in_data_byte = data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    // Bytes that complete no record stay in a bank and add no expected text.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_address(input logic [15:0] addr);
    cfg_valid         = 1'b1;
    cfg_start_address = addr;
    do @(posedge clk); while (!cfg_ready);
    tracker.load_start(addr);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly byte streams closed by an end item; some streams are left open.
  task automatic run_traffic(input int n_items, input int hold_after);
    int sent;
    int len;
    int choice;
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(99);
      len = (choice < 12) ? $urandom_range(17, 50) : $urandom_range(0, 16);
      for (int i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(255)));
      if (choice < 88) send_item(KIND_END, 8'($urandom_range(255)));
      sent += len + 1;
      if (hold_after > 0 && sent >= hold_after) begin
        long_hold_req = 1'b1;
        hold_after = 0;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] addr, input int s_pct, input int r_pct,
                           input int n_items, input int hold_after);
    wait_drained();
    write_start_address(addr);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    run_traffic(n_items, hold_after);
  endtask

  initial begin
    logic [7:0] wrap_bytes[6];
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_kind           = KIND_DATA;
    in_data_byte      = 8'h00;
    cfg_valid         = 1'b0;
    cfg_start_address = '0;
    send_idle_pct     = 31;
    recv_idle_pct     = 45;
    long_hold_req     = 1'b0;
    wrap_bytes        = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h55, 8'hAA};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset start address: a bare EOF record, then a short flushed record.
    send_item(KIND_END, 8'hFF);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_END, 8'h00);

    // A full record whose address range wraps past 0xFFFF, then one byte left
    // in the buffer across a start-address change.
    wait_drained();
    write_start_address(16'hFFF8);
    for (int i = 0; i < REC_BYTES; i++) begin
      send_item(KIND_DATA, (i < 6) ? wrap_bytes[i] : 8'($urandom_range(255)));
    end
    send_item(KIND_DATA, 8'h7E);
    wait_drained();
    write_start_address(16'hFFFF);
    send_item(KIND_END, 8'h5A);

    run_phase(16'($urandom_range(65535)), 31, 45, 80, 20);
    run_phase(16'h0000, 45, 31, 75, 0);
    run_phase(16'($urandom_range(16'hFF00, 16'hFFFF)), 0, 0, 70, 0);

    wait_drained();
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
